// File: src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros used by the RTL. NO_ASSERTIONS removes them all.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Plain property, checked on the rising clock edge outside reset.
`define ASSERT_RST(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("assertion failed");

// Overlapping implication, checked on the rising clock edge outside reset.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

`else

`define ASSERT_RST(lbl, clk, rst_n, prop)
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons)

`endif

`endif

// File: src/scsa_pkg.sv
// ----------------------------------------------------------------------------
// scsa_pkg
// Widths, limits and state codes of the sparse column sum and argmax block.
// ----------------------------------------------------------------------------
package scsa_pkg;

	localparam int MAX_USERS = 1024;
	localparam int ADDR_W    = $clog2(MAX_USERS);
	localparam int COL_W     = 10;
	localparam int VAL_W     = 32;
	localparam int TOT_W     = 48;
	localparam int CFG_W     = 11;
	// Wide enough for the user count register and for MAX_USERS itself.
	localparam int CNT_W     = (ADDR_W + 1 > CFG_W) ? ADDR_W + 1 : CFG_W;

	localparam logic [CFG_W-1:0]  NUM_USERS_RST = CFG_W'(1024);
	localparam logic [CNT_W-1:0]  MAX_USERS_CNT = CNT_W'(MAX_USERS);
	localparam logic [ADDR_W-1:0] LAST_ADDR     = ADDR_W'(MAX_USERS - 1);

	localparam logic [TOT_W-1:0] TOTAL_MAX = {1'b0, {(TOT_W-1){1'b1}}};
	localparam logic [TOT_W-1:0] TOTAL_MIN = {1'b1, {(TOT_W-1){1'b0}}};

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_ACCUM,
		ST_SCAN,
		ST_DRAIN,
		ST_DONE
	} state_t;

endpackage

// File: src/scsa_ram.sv
// ----------------------------------------------------------------------------
// scsa_ram
// Simple dual-port RAM, one write and one read port, registered read data.
// A read of the address written in the same cycle returns the old contents.
// ----------------------------------------------------------------------------
module scsa_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// File: src/sparse_column_sum_argmax.sv
// ----------------------------------------------------------------------------
// sparse_column_sum_argmax
// Column totals of a sparse matrix held in one RAM, with an argmax scan.
//
// The item channel (item_valid, item_stall) carries one non-zero entry per
// transfer: column, value and last. Each entry is added into the 48-bit
// saturating total of its column by a read-modify-write on the totals RAM;
// a one-entry forwarding register covers back-to-back entries of the same
// column. Entries whose column is at or beyond num_users are dropped.
// Non-last entries stream at one per cycle between sweeps.
// An entry flagged last is accumulated, then the block sweeps the whole
// RAM once, one address per cycle, comparing the columns below num_users
// and writing zeros behind the sweep. The result (best_user, best_total)
// is registered after the drain and done states, once the output register
// is free, and the next entry can be taken in the same cycle as the result
// becomes valid; item_stall stays high until then. After reset the same
// sweep clears the whole RAM with item_stall high; cfg writes are taken at
// any time. A result waiting under result_stall does not block new entries;
// only the next sweep's result waits until the output register is free.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sparse_column_sum_argmax (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_wr_en,
	input  logic [scsa_pkg::CFG_W-1:0]        cfg_wr_data,
	input  logic                              item_valid,
	output logic                              item_stall,
	input  logic [scsa_pkg::COL_W-1:0]        column,
	input  logic signed [scsa_pkg::VAL_W-1:0] value,
	input  logic                              last,
	output logic                              result_valid,
	input  logic                              result_stall,
	output logic [scsa_pkg::COL_W-1:0]        best_user,
	output logic signed [scsa_pkg::TOT_W-1:0] best_total
);

	localparam int AW = scsa_pkg::ADDR_W;
	localparam int TW = scsa_pkg::TOT_W;
	localparam int VW = scsa_pkg::VAL_W;
	localparam int CW = scsa_pkg::CNT_W;

	scsa_pkg::state_t state_q, state_d;

	logic [scsa_pkg::CFG_W-1:0] num_users_q;
	logic [CW-1:0]              active_cnt;

	logic [AW-1:0] sweep_q;
	logic          sweep_end;

	// Accumulate stage
	logic          acc_vld_s1, acc_last_s1, acc_en_s1;
	logic [AW-1:0] acc_addr_s1;
	logic [VW-1:0] acc_val_s1;

	logic          fwd_en_q;
	logic [AW-1:0] fwd_addr_q;
	logic [TW-1:0] fwd_data_q;

	// Scan stage
	logic          scan_vld_s1;
	logic [AW-1:0] scan_idx_s1;
	logic [TW-1:0] best_q;
	logic [AW-1:0] best_idx_q;

	logic                 result_valid_q;
	logic [AW-1:0]        result_user_q;
	logic [TW-1:0]        result_total_q;

	logic          item_xfer;
	logic          out_free;
	logic          acc_we;
	logic [TW-1:0] base;
	logic [TW:0]   sum_wide;
	logic [TW-1:0] sum_sat;

	logic          ram_we;
	logic [AW-1:0] ram_waddr, ram_raddr;
	logic [TW-1:0] ram_wdata, ram_rdata;

	logic scan_hit;

	assign active_cnt = (CW'(num_users_q) > scsa_pkg::MAX_USERS_CNT) ?
		scsa_pkg::MAX_USERS_CNT : CW'(num_users_q);

	assign sweep_end = (sweep_q == scsa_pkg::LAST_ADDR);
	assign item_xfer = item_valid && !item_stall;
	assign out_free  = !result_valid_q || !result_stall;

	// The forwarded value is the write that lands in the same cycle as this
	// entry's RAM read, which the RAM itself does not yet return.
	assign base = (fwd_en_q && fwd_addr_q == acc_addr_s1) ? fwd_data_q : ram_rdata;

	assign sum_wide = {base[TW-1], base} +
		{{(TW + 1 - VW){acc_val_s1[VW-1]}}, acc_val_s1};

	always_comb begin
		if (sum_wide[TW] != sum_wide[TW-1]) begin
			sum_sat = sum_wide[TW] ? scsa_pkg::TOTAL_MIN : scsa_pkg::TOTAL_MAX;
		end else begin
			sum_sat = sum_wide[TW-1:0];
		end
	end

	assign acc_we = acc_vld_s1 && acc_en_s1;

	assign scan_hit = scan_vld_s1 && (CW'(scan_idx_s1) < active_cnt) &&
		($signed(ram_rdata) > $signed(best_q));

	always_comb begin
		state_d    = state_q;
		item_stall = 1'b1;
		ram_raddr  = sweep_q;
		ram_we     = 1'b0;
		ram_waddr  = sweep_q;
		ram_wdata  = '0;
		case (state_q)
			scsa_pkg::ST_CLEAR: begin
				ram_we = 1'b1;
				if (sweep_end) begin
					state_d = scsa_pkg::ST_ACCUM;
				end
			end
			scsa_pkg::ST_ACCUM: begin
				item_stall = acc_vld_s1 && acc_last_s1;
				ram_raddr  = AW'(column);
				ram_we     = acc_we;
				ram_waddr  = acc_addr_s1;
				ram_wdata  = sum_sat;
				if (acc_vld_s1 && acc_last_s1) begin
					state_d = scsa_pkg::ST_SCAN;
				end
			end
			scsa_pkg::ST_SCAN: begin
				// Read-first RAM: the old total is read while zero goes in.
				ram_we = 1'b1;
				if (sweep_end) begin
					state_d = scsa_pkg::ST_DRAIN;
				end
			end
			scsa_pkg::ST_DRAIN: begin
				state_d = scsa_pkg::ST_DONE;
			end
			scsa_pkg::ST_DONE: begin
				if (out_free) begin
					state_d = scsa_pkg::ST_ACCUM;
				end
			end
			default: begin
				state_d = scsa_pkg::ST_CLEAR;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= scsa_pkg::ST_CLEAR;
			num_users_q    <= scsa_pkg::NUM_USERS_RST;
			sweep_q        <= '0;
			acc_vld_s1     <= 1'b0;
			fwd_en_q       <= 1'b0;
			scan_vld_s1    <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_wr_en) begin
				num_users_q <= cfg_wr_data;
			end
			if (state_q inside {scsa_pkg::ST_CLEAR, scsa_pkg::ST_SCAN}) begin
				sweep_q <= sweep_end ? '0 : sweep_q + AW'(1);
			end
			acc_vld_s1  <= item_xfer;
			fwd_en_q    <= acc_we;
			scan_vld_s1 <= (state_q == scsa_pkg::ST_SCAN);
			if (state_q == scsa_pkg::ST_DONE && out_free) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item_xfer) begin
			acc_addr_s1 <= AW'(column);
			acc_val_s1  <= value;
			acc_last_s1 <= last;
			acc_en_s1   <= CW'(column) < active_cnt;
		end
		fwd_addr_q  <= acc_addr_s1;
		fwd_data_q  <= sum_sat;
		scan_idx_s1 <= sweep_q;
		if (state_q == scsa_pkg::ST_ACCUM) begin
			best_q     <= '0;
			best_idx_q <= '0;
		end else if (scan_hit) begin
			best_q     <= ram_rdata;
			best_idx_q <= scan_idx_s1;
		end
		if (state_q == scsa_pkg::ST_DONE && out_free) begin
			result_user_q  <= best_idx_q;
			result_total_q <= best_q;
		end
	end

	scsa_ram #(
		.WIDTH(TW),
		.DEPTH(scsa_pkg::MAX_USERS)
	) u_totals (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign result_valid = result_valid_q;
	assign best_user    = scsa_pkg::COL_W'(result_user_q);
	assign best_total   = $signed(result_total_q);

	`ASSERT_IMPL(a_acc_wr_in_accum, clk, arst_n, acc_we, state_q == scsa_pkg::ST_ACCUM)
	`ASSERT_RST(a_last_blocks_next, clk, arst_n, (item_xfer && last) |=> item_stall)
	`ASSERT_IMPL(a_result_from_done, clk, arst_n, $rose(result_valid_q), $past(state_q) == scsa_pkg::ST_DONE)
	`ASSERT_IMPL(a_drain_last_index, clk, arst_n, state_q == scsa_pkg::ST_DRAIN, scan_vld_s1 && scan_idx_s1 == scsa_pkg::LAST_ADDR)

endmodule

// File: verif/sparse_column_sum_argmax_tb.sv
// ----------------------------------------------------------------------------
// sparse_column_sum_argmax_tb
// Streams sparse entries into the column sum and argmax block under random
// idling on both channels. Every accepted entry is folded into a copy of the
// column totals here, and each entry flagged last predicts the best column.
// Results are compared with those predictions in order. The run covers
// several user counts, both value extremes and the case with no positive
// total.
// ----------------------------------------------------------------------------
module sparse_column_sum_argmax_tb;

	localparam int N_COLS     = scsa_pkg::MAX_USERS;
	localparam int SETTLE     = 16;
	localparam int END_WAIT   = scsa_pkg::MAX_USERS + 16;
	localparam logic signed [49:0] SUM_HI = $signed({2'b00, scsa_pkg::TOTAL_MAX});
	localparam logic signed [49:0] SUM_LO = $signed({2'b11, scsa_pkg::TOTAL_MIN});

	typedef struct {
		logic [scsa_pkg::COL_W-1:0]        col;
		logic signed [scsa_pkg::VAL_W-1:0] val;
		logic                              is_last;
	} entry_t;

	typedef struct {
		logic [scsa_pkg::COL_W-1:0]        user;
		logic signed [scsa_pkg::TOT_W-1:0] total;
	} winner_t;

	logic                              clk = 1'b0;
	logic                              arst_n = 1'b0;
	logic                              cfg_wr_en = 1'b0;
	logic [scsa_pkg::CFG_W-1:0]        cfg_wr_data = '0;
	logic                              item_valid = 1'b0;
	logic                              item_stall;
	logic [scsa_pkg::COL_W-1:0]        column = '0;
	logic signed [scsa_pkg::VAL_W-1:0] value = '0;
	logic                              last = 1'b0;
	logic                              result_valid;
	logic                              result_stall = 1'b0;
	logic [scsa_pkg::COL_W-1:0]        best_user;
	logic signed [scsa_pkg::TOT_W-1:0] best_total;

	entry_t  pending_entries[$];
	winner_t due_winners[$];
	logic signed [scsa_pkg::TOT_W-1:0] col_totals [N_COLS];
	logic [scsa_pkg::CFG_W-1:0]        users_cfg = scsa_pkg::NUM_USERS_RST;

	bit     idle_on = 1'b1;
	int     gap_left = 0;
	int     stall_left = 0;
	int     err_cnt = 0;
	entry_t cur;

	sparse_column_sum_argmax dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.column       (column),
		.value        (value),
		.last         (last),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.best_user    (best_user),
		.best_total   (best_total)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#100_000_000;
		$display("TB_ERROR");
		$finish;
	end

	function automatic int unsigned scan_span();
		return (users_cfg > N_COLS) ? N_COLS : users_cfg;
	endfunction

	// Folds one accepted entry into the totals; a last entry yields the winner.
	task automatic accumulate_entry(input entry_t e);
		int unsigned span;
		logic signed [49:0] sum;
		logic signed [scsa_pkg::TOT_W-1:0] best;
		int unsigned best_idx;
		winner_t w;
		span = scan_span();
		if (e.col < span) begin
			sum = 50'(col_totals[e.col]) + 50'(e.val);
			if (sum > SUM_HI)
				sum = SUM_HI;
			if (sum < SUM_LO)
				sum = SUM_LO;
			col_totals[e.col] = sum[scsa_pkg::TOT_W-1:0];
		end
		if (e.is_last) begin
			best = '0;
			best_idx = 0;
			for (int i = 0; i < span; i++) begin
				if (col_totals[i] > best) begin
					best = col_totals[i];
					best_idx = i;
				end
			end
			w.user = best_idx[scsa_pkg::COL_W-1:0];
			w.total = best;
			due_winners.push_back(w);
			for (int i = 0; i < N_COLS; i++)
				col_totals[i] = '0;
		end
	endtask

	// Entry driver: holds the payload while stalled, idles only between transfers.
	always @(posedge clk) begin
		if (arst_n) begin
			if (item_valid && !item_stall)
				accumulate_entry('{column, value, last});
			if (!item_valid || !item_stall) begin
				if (gap_left != 0) begin
					gap_left--;
					item_valid <= 1'b0;
				end else if (idle_on && $urandom_range(0, 9) == 0) begin
					gap_left = $urandom_range(0, 15);
					item_valid <= 1'b0;
				end else if (pending_entries.size() != 0) begin
					cur = pending_entries.pop_front();
					column <= cur.col;
					value <= cur.val;
					last <= cur.is_last;
					item_valid <= 1'b1;
				end else begin
					item_valid <= 1'b0;
				end
			end
		end
	end

	// Result monitor with random stall bursts.
	always @(posedge clk) begin
		winner_t w;
		if (arst_n) begin
			if (result_valid && !result_stall) begin
				if (due_winners.size() == 0) begin
					$display("%0t unexpected result: user %0d total %0d", $time,
						best_user, best_total);
					err_cnt++;
				end else begin
					w = due_winners.pop_front();
					if (best_user !== w.user) begin
						$display("%0t best_user mismatch: expected %0d, got %0d", $time,
							w.user, best_user);
						err_cnt++;
					end
					if (best_total !== w.total) begin
						$display("%0t best_total mismatch: expected %0d, got %0d", $time,
							w.total, best_total);
						err_cnt++;
					end
				end
			end
			if (stall_left != 0) begin
				stall_left--;
				result_stall <= 1'b1;
			end else if (idle_on && $urandom_range(0, 9) == 0) begin
				stall_left = $urandom_range(0, 15);
				result_stall <= 1'b1;
			end else begin
				result_stall <= 1'b0;
			end
		end
	end

	task automatic push_entry(input logic [scsa_pkg::COL_W-1:0] c,
			input logic signed [scsa_pkg::VAL_W-1:0] v, input logic l);
		entry_t e;
		e.col = c;
		e.val = v;
		e.is_last = l;
		pending_entries.push_back(e);
	endtask

	// Waits until every queued entry has gone and every predicted result has come.
	task automatic wait_idle();
		while (pending_entries.size() != 0 || item_valid || due_winners.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_users(input logic [scsa_pkg::CFG_W-1:0] n);
		wait_idle();
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= n;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		users_cfg = n;
	endtask

	// Often one of the first eight columns so that totals compete, sometimes out of range.
	function automatic logic [scsa_pkg::COL_W-1:0] pick_column(input int unsigned span);
		int unsigned r;
		r = $urandom_range(0, 9);
		if (span == 0 || r == 0)
			return scsa_pkg::COL_W'($urandom);
		if (r <= 4)
			return scsa_pkg::COL_W'($urandom_range(0, ((span < 8) ? span : 8) - 1));
		return scsa_pkg::COL_W'($urandom_range(0, span - 1));
	endfunction

	function automatic logic signed [scsa_pkg::VAL_W-1:0] pick_value();
		case ($urandom_range(0, 7))
			0: return 32'sh7FFF_FFFF;
			1: return 32'sh8000_0000;
			2: return $signed($urandom_range(0, 200)) - 100;
			default: return $urandom;
		endcase
	endfunction

	task automatic random_phase(input logic [scsa_pkg::CFG_W-1:0] n, input int n_items);
		int made;
		int set_len;
		int unsigned span;
		write_users(n);
		span = scan_span();
		made = 0;
		while (made < n_items) begin
			set_len = ($urandom_range(0, 7) == 0) ? 1 : $urandom_range(2, 30);
			for (int k = 0; k < set_len; k++)
				push_entry(pick_column(span), pick_value(), k == set_len - 1);
			made += set_len;
		end
	endtask

	initial begin
		for (int i = 0; i < N_COLS; i++)
			col_totals[i] = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// Directed entries at the reset user count. Nothing positive: column 0, total 0.
		push_entry(10'd5, -32'sd7, 1'b1);
		// Both value extremes and both column extremes.
		push_entry(10'd1023, 32'sh7FFF_FFFF, 1'b0);
		push_entry(10'd0, 32'sh8000_0000, 1'b0);
		push_entry(10'd1023, 32'sd1, 1'b1);
		// A tie goes to the lower column.
		push_entry(10'd3, 32'sd100, 1'b0);
		push_entry(10'd7, 32'sd100, 1'b0);
		push_entry(10'd500, -32'sd1, 1'b1);
		// Back-to-back entries of one column.
		push_entry(10'd9, 32'sd10, 1'b0);
		push_entry(10'd9, 32'sd20, 1'b0);
		push_entry(10'd9, -32'sd5, 1'b0);
		push_entry(10'd9, 32'sd1, 1'b1);
		// A later column with a larger total wins; a total driven negative loses.
		push_entry(10'd2, 32'sd50, 1'b0);
		push_entry(10'd600, 32'sd80, 1'b0);
		push_entry(10'd2, -32'sd60, 1'b0);
		push_entry(10'd601, 32'sd79, 1'b1);

		// One user: other columns are dropped, even on the last entry.
		write_users(11'd1);
		push_entry(10'd0, 32'sd5, 1'b0);
		push_entry(10'd1, 32'sd100, 1'b0);
		push_entry(10'd700, 32'sd9, 1'b1);
		// Zero users: nothing is scanned.
		write_users(11'd0);
		push_entry(10'd0, 32'sd50, 1'b0);
		push_entry(10'd0, 32'sd50, 1'b1);
		// A count above the column store is clamped.
		write_users(11'h7FF);
		push_entry(10'd1023, 32'sd3, 1'b0);
		push_entry(10'd1022, 32'sd2, 1'b1);

		random_phase(11'd2, 150);
		random_phase(11'd16, 150);
		random_phase(scsa_pkg::CFG_W'($urandom_range(0, 2047)), 150);
		random_phase(11'd1024, 150);
		random_phase(11'd5, 150);
		random_phase(11'd1000, 150);
		random_phase(scsa_pkg::CFG_W'($urandom_range(1, 64)), 150);

		wait_idle();
		idle_on = 1'b0;
		random_phase(11'd1024, 150);

		wait_idle();
		repeat (END_WAIT) @(posedge clk);
		if (err_cnt == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

// File: sparse_column_sum_argmax.f
+incdir+src
src/scsa_pkg.sv
src/scsa_ram.sv
src/sparse_column_sum_argmax.sv
verif/sparse_column_sum_argmax_tb.sv
